// File: hw/rtl/dsac_pkg.sv
// Shared constants, types and state codes for the dust sample averaging and
// calibration block. Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package dsac_pkg;

    // Averaging window depth (1 to 64)
    localparam int WINDOW = 10;

    localparam int ADC_W  = 12;
    localparam int MV_W   = 13;
    localparam int CONC_W = 9;

    localparam int SUM_W  = $clog2(WINDOW * 4095 + 1);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Product and divider width, wide enough for filtered * ref; two bits a cycle
    localparam int DIV_W      = 26;
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [MV_W-1:0]   ADC_FULL_SCALE = 13'd4095;
    localparam logic [MV_W-1:0]   STEP_UG        = 13'd100;
    localparam logic [CONC_W-1:0] CONC_MAX       = 9'd500;

    localparam int NUM_BREAKS = 6;
    localparam int NUM_SEGS   = NUM_BREAKS - 1;
    localparam int SEG_W      = $clog2(NUM_SEGS);
    localparam int BRK_IDX_W  = $clog2(NUM_BREAKS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRK0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRK5 = 3'd6;

    localparam logic [MV_W-1:0] REF_RESET = 13'd3300;
    localparam logic [MV_W-1:0] BRK_RESET [NUM_BREAKS] =
        '{13'd950, 13'd1450, 13'd2000, 13'd2650, 13'd3250, 13'd3600};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_AVG_WAIT,
        ST_MV,
        ST_MV_WAIT,
        ST_SCAN,
        ST_CAL,
        ST_CAL_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [MV_W-1:0]  divisor;
    } t_div_req;

endpackage

// File: hw/rtl/dsac_div.sv
// Iterative restoring divider shared by the averaging and interpolation
// steps. Retires two quotient bits per cycle. Uses dsac_pkg.
`timescale 1ns / 1ps

module dsac_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dsac_pkg::t_div_req        i_req,
    output logic                      o_done,
    output logic [dsac_pkg::DIV_W-1:0] o_quotient
);

    logic [dsac_pkg::DIV_W-1:0]     r_quo;
    logic [dsac_pkg::MV_W-1:0]      r_rem;
    logic [dsac_pkg::MV_W-1:0]      r_divisor;
    logic [dsac_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [dsac_pkg::DIV_W-1:0]     n_quo;
    logic [dsac_pkg::MV_W-1:0]      n_rem;

    always_comb begin
        logic [dsac_pkg::MV_W:0]    trial;
        logic [dsac_pkg::DIV_W-1:0] quo;
        logic [dsac_pkg::MV_W-1:0]  rem;
        quo = r_quo;
        rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            // shift in the next dividend bit, subtract when it fits
            trial = {rem, quo[dsac_pkg::DIV_W-1]};
            quo   = {quo[dsac_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_divisor}) begin
                trial  = trial - {1'b0, r_divisor};
                quo[0] = 1'b1;
            end
            rem = trial[dsac_pkg::MV_W-1:0];
        end
        n_quo = quo;
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= dsac_pkg::DIV_CNT_W'(dsac_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == dsac_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/dsac_window.sv
// Sample ring with running sum and fill count for the moving average.
// Uses dsac_pkg for the window depth and widths.
`timescale 1ns / 1ps

module dsac_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [dsac_pkg::ADC_W-1:0]  i_sample,
    output logic [dsac_pkg::SUM_W-1:0]  o_sum,
    output logic [dsac_pkg::FILL_W-1:0] o_fill
);

    logic [dsac_pkg::ADC_W-1:0]  r_ring [dsac_pkg::WINDOW];
    logic [dsac_pkg::SUM_W-1:0]  r_sum;
    logic [dsac_pkg::SLOT_W-1:0] r_slot;
    logic [dsac_pkg::FILL_W-1:0] r_fill;

    logic [dsac_pkg::SUM_W-1:0]  n_sum;
    logic [dsac_pkg::SLOT_W-1:0] n_slot;

    always_comb begin
        // drop the oldest sample, add the new one
        n_sum = r_sum - dsac_pkg::SUM_W'(r_ring[r_slot])
                      + dsac_pkg::SUM_W'(i_sample);
        if (r_slot == dsac_pkg::SLOT_W'(dsac_pkg::WINDOW - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dsac_pkg::WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_sum  <= '0;
            r_slot <= '0;
            r_fill <= '0;
        end else if (i_push) begin
            r_ring[r_slot] <= i_sample;
            r_sum          <= n_sum;
            r_slot         <= n_slot;
            if (r_fill != dsac_pkg::FILL_W'(dsac_pkg::WINDOW)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_fill = r_fill;

endmodule

// File: hw/rtl/dust_sample_average_and_calibrate.sv
// Top level of the dust sample averaging and calibration block: stream
// ports, configuration registers and the sequencer. Uses dsac_pkg,
// dsac_window and dsac_div.
`timescale 1ns / 1ps

// One accepted 12-bit sample produces one result: the truncated moving
// average over the last WINDOW samples (fewer right after reset), that value
// scaled to millivolts against ref_millivolts, and a concentration in ug/m3
// interpolated over the six millivolt breakpoints. An item makes up to two
// passes through the one shared divider, at two quotient bits per cycle, for
// the average and the interpolation; the divide by 4095 for the millivolt
// scaling does not use the divider, as the product is registered in r_prod
// and the folded quotient in r_mv. When the voltage falls outside every
// segment or on a zero-width segment the interpolation pass is skipped.
// s_axis_tready is high only while the sequencer is idle, so a new sample is
// not taken until the last result has been loaded into the output register;
// a finished result waits in the output register while the next sample is
// taken. Configuration writes are taken at any cycle but must be made while
// no sample is in work.
module dust_sample_average_and_calibrate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [11:0] adc_sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] filtered_adc, [24:12] voltage_mv, [33:25] concentration_ug
    output logic [39:0]                         m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [dsac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dsac_pkg::MV_W-1:0]           i_cfg_wdata
);

    dsac_pkg::t_state r_state;
    dsac_pkg::t_state n_state;

    logic [dsac_pkg::MV_W-1:0]   r_ref;
    logic [dsac_pkg::MV_W-1:0]   r_brk [dsac_pkg::NUM_BREAKS];

    logic [dsac_pkg::ADC_W-1:0]  r_filt;
    logic [dsac_pkg::DIV_W-1:0]  r_prod;
    logic [dsac_pkg::MV_W-1:0]   r_mv;
    logic [dsac_pkg::CONC_W-1:0] r_conc;
    logic                        r_hit;
    logic [dsac_pkg::SEG_W-1:0]  r_seg;
    logic [dsac_pkg::MV_W-1:0]   r_diff;
    logic [dsac_pkg::MV_W-1:0]   r_span;

    logic                        r_m_valid;
    logic [dsac_pkg::ADC_W-1:0]  r_out_filt;
    logic [dsac_pkg::MV_W-1:0]   r_out_mv;
    logic [dsac_pkg::CONC_W-1:0] r_out_conc;

    logic [dsac_pkg::SUM_W-1:0]  w_sum;
    logic [dsac_pkg::FILL_W-1:0] w_fill;
    logic                        w_div_done;
    logic [dsac_pkg::DIV_W-1:0]  w_quotient;
    dsac_pkg::t_div_req          w_div_req;

    logic                        w_accept;
    logic                        w_out_free;
    logic [dsac_pkg::MV_W-1:0]   w_mul_a;
    logic [dsac_pkg::MV_W-1:0]   w_mul_b;
    logic [dsac_pkg::DIV_W-1:0]  w_product;
    logic                        w_ld_filt;
    logic                        w_ld_prod;
    logic                        w_ld_mv;
    logic                        w_ld_scan;
    logic                        w_ld_conc;
    logic [dsac_pkg::CONC_W-1:0] w_conc_val;
    logic                        w_ld_out;

    logic [dsac_pkg::MV_W-1:0]   w_mv_hi;
    logic [dsac_pkg::ADC_W-1:0]  w_mv_lo;
    logic [dsac_pkg::MV_W:0]     w_mv_fold;
    logic [dsac_pkg::MV_W-1:0]   w_mv_quot;

    logic                        w_scan_hit;
    logic [dsac_pkg::SEG_W-1:0]  w_scan_seg;
    logic [dsac_pkg::MV_W-1:0]   w_scan_diff;
    logic [dsac_pkg::MV_W-1:0]   w_scan_span;
    logic [dsac_pkg::CONC_W-1:0] w_seg_base;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_product  = dsac_pkg::DIV_W'(w_mul_a) * dsac_pkg::DIV_W'(w_mul_b);
    assign w_seg_base = dsac_pkg::CONC_W'(dsac_pkg::STEP_UG * dsac_pkg::MV_W'(r_seg));

    // Divide the product by 4095: since 4096 = 4095 + 1, fold the high part
    // back onto the low part and correct by at most two
    assign w_mv_hi   = r_prod[dsac_pkg::ADC_W +: dsac_pkg::MV_W];
    assign w_mv_lo   = r_prod[dsac_pkg::ADC_W-1:0];
    assign w_mv_fold = {1'b0, w_mv_hi} + (dsac_pkg::MV_W+1)'(w_mv_lo);

    always_comb begin
        if (w_mv_fold >= {dsac_pkg::ADC_FULL_SCALE, 1'b0}) begin
            w_mv_quot = w_mv_hi + dsac_pkg::MV_W'(2);
        end else if (w_mv_fold >= {1'b0, dsac_pkg::ADC_FULL_SCALE}) begin
            w_mv_quot = w_mv_hi + dsac_pkg::MV_W'(1);
        end else begin
            w_mv_quot = w_mv_hi;
        end
    end

    dsac_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_sample (s_axis_tdata[dsac_pkg::ADC_W-1:0]),
        .o_sum    (w_sum),
        .o_fill   (w_fill)
    );

    dsac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= dsac_pkg::REF_RESET;
            for (int i = 0; i < dsac_pkg::NUM_BREAKS; i++) begin
                r_brk[i] <= dsac_pkg::BRK_RESET[i];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == dsac_pkg::CFG_REF) begin
                r_ref <= i_cfg_wdata;
            end else if (i_cfg_index >= dsac_pkg::CFG_BRK0 &&
                         i_cfg_index <= dsac_pkg::CFG_BRK5) begin
                r_brk[dsac_pkg::BRK_IDX_W'(i_cfg_index - dsac_pkg::CFG_BRK0)] <= i_cfg_wdata;
            end
        end
    end

    // Segment search: all segments compared at once, first match wins
    always_comb begin
        logic [dsac_pkg::NUM_SEGS-1:0] match;
        logic                          seen;
        match       = '0;
        seen        = 1'b0;
        w_scan_seg  = '0;
        w_scan_diff = '0;
        w_scan_span = '0;
        for (int i = 0; i < dsac_pkg::NUM_SEGS; i++) begin
            match[i] = (r_mv >= r_brk[i]) && (r_mv <= r_brk[i+1]);
            if (match[i] && !seen) begin
                w_scan_seg  = dsac_pkg::SEG_W'(i);
                w_scan_diff = r_mv - r_brk[i];
                w_scan_span = r_brk[i+1] - r_brk[i];
            end
            seen = seen || match[i];
        end
        w_scan_hit = seen;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dsac_pkg::ST_IDLE:     if (w_accept) n_state = dsac_pkg::ST_AVG;
            dsac_pkg::ST_AVG:      n_state = dsac_pkg::ST_AVG_WAIT;
            dsac_pkg::ST_AVG_WAIT: if (w_div_done) n_state = dsac_pkg::ST_MV;
            dsac_pkg::ST_MV:       n_state = dsac_pkg::ST_MV_WAIT;
            dsac_pkg::ST_MV_WAIT:  n_state = dsac_pkg::ST_SCAN;
            dsac_pkg::ST_SCAN:     n_state = dsac_pkg::ST_CAL;
            dsac_pkg::ST_CAL: begin
                if (r_hit && r_span != '0) begin
                    n_state = dsac_pkg::ST_CAL_WAIT;
                end else begin
                    n_state = dsac_pkg::ST_OUT;
                end
            end
            dsac_pkg::ST_CAL_WAIT: if (w_div_done) n_state = dsac_pkg::ST_OUT;
            dsac_pkg::ST_OUT:      if (w_out_free) n_state = dsac_pkg::ST_IDLE;
            default:               n_state = dsac_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready      = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_product;
        w_div_req.divisor  = r_span;
        w_mul_a            = dsac_pkg::MV_W'(r_filt);
        w_mul_b            = r_ref;
        w_ld_filt          = 1'b0;
        w_ld_prod          = 1'b0;
        w_ld_mv            = 1'b0;
        w_ld_scan          = 1'b0;
        w_ld_conc          = 1'b0;
        w_conc_val         = '0;
        w_ld_out           = 1'b0;
        case (r_state)
            dsac_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            dsac_pkg::ST_AVG: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = dsac_pkg::DIV_W'(w_sum);
                w_div_req.divisor  = dsac_pkg::MV_W'(w_fill);
            end
            dsac_pkg::ST_AVG_WAIT: begin
                w_ld_filt = w_div_done;
            end
            dsac_pkg::ST_MV: begin
                w_ld_prod = 1'b1;
            end
            dsac_pkg::ST_MV_WAIT: begin
                w_ld_mv = 1'b1;
            end
            dsac_pkg::ST_SCAN: begin
                w_ld_scan = 1'b1;
            end
            dsac_pkg::ST_CAL: begin
                w_mul_a = r_diff;
                w_mul_b = dsac_pkg::STEP_UG;
                if (!r_hit) begin
                    w_ld_conc = 1'b1;
                    // above the last breakpoint and not below the first saturates, anything else reads zero
                    if (r_mv > r_brk[dsac_pkg::NUM_BREAKS-1] && r_mv >= r_brk[0]) begin
                        w_conc_val = dsac_pkg::CONC_MAX;
                    end
                end else if (r_span == '0) begin
                    w_ld_conc  = 1'b1;
                    w_conc_val = w_seg_base;
                end else begin
                    w_div_req.start   = 1'b1;
                    w_div_req.divisor = r_span;
                end
            end
            dsac_pkg::ST_CAL_WAIT: begin
                w_ld_conc  = w_div_done;
                w_conc_val = w_seg_base + dsac_pkg::CONC_W'(w_quotient);
            end
            dsac_pkg::ST_OUT: begin
                w_ld_out = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_filt) r_filt <= w_quotient[dsac_pkg::ADC_W-1:0];
        if (w_ld_prod) r_prod <= w_product;
        if (w_ld_mv)   r_mv   <= w_mv_quot;
        if (w_ld_scan) begin
            r_hit  <= w_scan_hit;
            r_seg  <= w_scan_seg;
            r_diff <= w_scan_diff;
            r_span <= w_scan_span;
        end
        if (w_ld_conc) r_conc <= w_conc_val;
    end

    // Output register: hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ld_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_out_filt <= r_filt;
            r_out_mv   <= r_mv;
            r_out_conc <= r_conc;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_out_conc, r_out_mv, r_out_filt};

`ifndef SYNTHESIS
    a_accept_starts_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == dsac_pkg::ST_AVG))
        else $error("accepted sample did not start the average step");

    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsac_pkg::ST_AVG) |-> (w_fill != '0))
        else $error("average started with an empty window");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == dsac_pkg::ST_AVG_WAIT ||
                        r_state == dsac_pkg::ST_CAL_WAIT))
        else $error("divider finished outside a wait state");

    a_conc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_conc <= dsac_pkg::CONC_MAX))
        else $error("concentration above full scale");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for dust_sample_average_and_calibrate: streams ADC samples,
// predicts average, millivolts and concentration per sample and checks every result.
// Depends on dsac_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [dsac_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [dsac_pkg::ADC_W-1:0]  filtered;
        logic [dsac_pkg::MV_W-1:0]   millivolts;
        logic [dsac_pkg::CONC_W-1:0] conc;
    } t_avg_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata;   // [11:0] adc_sample
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // [11:0] filtered_adc, [24:12] voltage_mv, [33:25] concentration_ug
    logic [39:0]                    m_axis_tdata;
    logic                           i_cfg_we;
    logic [dsac_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [dsac_pkg::MV_W-1:0]      i_cfg_wdata;

    // Predictor state
    logic [dsac_pkg::ADC_W-1:0] avg_ring [dsac_pkg::WINDOW];
    int unsigned                avg_sum;
    int unsigned                avg_slot;
    int unsigned                avg_fill;
    logic [dsac_pkg::MV_W-1:0]  cal_ref_mv;
    logic [dsac_pkg::MV_W-1:0]  cal_break [dsac_pkg::NUM_BREAKS];
    t_avg_result                pending_results [$];
    t_avg_result                head_result;

    int unsigned mismatch_count;
    int unsigned cycle_count;
    bit          steady;       // no idling on either side
    int unsigned rx_hold;      // long output hold-off requested by a test
    int unsigned rx_stall;

    dust_sample_average_and_calibrate DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    function automatic logic [dsac_pkg::CONC_W-1:0] interpolate_conc(input int unsigned mv);
        int unsigned lo, hi, conc;
        bit          found;
        conc  = 0;
        found = 1'b0;
        // first segment that contains the voltage wins
        for (int i = 0; i < dsac_pkg::NUM_SEGS; i++) begin
            lo = cal_break[i];
            hi = cal_break[i+1];
            if (!found && mv >= lo && mv <= hi) begin
                found = 1'b1;
                conc  = int'(dsac_pkg::STEP_UG) * i;
                if (hi != lo)
                    conc = conc + ((mv - lo) * int'(dsac_pkg::STEP_UG)) / (hi - lo);
            end
        end
        // below the first breakpoint reads zero even when it is also above the last
        if (!found && mv >= cal_break[0] && mv > cal_break[dsac_pkg::NUM_BREAKS-1])
            conc = int'(dsac_pkg::CONC_MAX);
        return conc[dsac_pkg::CONC_W-1:0];
    endfunction

    function automatic void average_and_calibrate(input logic [dsac_pkg::ADC_W-1:0] sample);
        t_avg_result r;
        int unsigned filt, mv;
        avg_sum = avg_sum - avg_ring[avg_slot] + sample;
        avg_ring[avg_slot] = sample;
        avg_slot = (avg_slot + 1 >= dsac_pkg::WINDOW) ? 0 : avg_slot + 1;
        if (avg_fill < dsac_pkg::WINDOW)
            avg_fill++;
        filt = avg_sum / avg_fill;
        mv   = (filt * cal_ref_mv) / int'(dsac_pkg::ADC_FULL_SCALE);
        r.filtered   = filt[dsac_pkg::ADC_W-1:0];
        r.millivolts = mv[dsac_pkg::MV_W-1:0];
        r.conc       = interpolate_conc(mv);
        pending_results.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata[11:0], 0);
            end else begin
                head_result = pending_results.pop_front();
                if (m_axis_tdata[11:0] !== head_result.filtered)
                    report_mismatch("filtered_adc", m_axis_tdata[11:0], head_result.filtered);
                if (m_axis_tdata[24:12] !== head_result.millivolts)
                    report_mismatch("voltage_mv", m_axis_tdata[24:12], head_result.millivolts);
                if (m_axis_tdata[33:25] !== head_result.conc)
                    report_mismatch("concentration_ug", m_axis_tdata[33:25], head_result.conc);
            end
        end
    end

    // Result side: random stall before each transaction unless steady, plus long hold-offs on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold != 0) begin
                m_axis_tready = 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end
            rx_stall = steady ? 0 : $urandom_range(0, 15);
            if (rx_stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (rx_stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Returns at a falling edge with tvalid still high, so back-to-back samples keep it up
    task automatic send_sample(input logic [dsac_pkg::ADC_W-1:0] sample);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {4'b0, sample};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        average_and_calibrate(sample);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_register(input logic [dsac_pkg::CFG_IDX_W-1:0] index,
                                  input int unsigned value);
        s_axis_tvalid = 1'b0;
        i_cfg_we      = 1'b1;
        i_cfg_index   = index;
        i_cfg_wdata   = value[dsac_pkg::MV_W-1:0];
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        if (index == dsac_pkg::CFG_REF)
            cal_ref_mv = value[dsac_pkg::MV_W-1:0];
        else if (index >= dsac_pkg::CFG_BRK0 && index <= dsac_pkg::CFG_BRK5)
            cal_break[index - dsac_pkg::CFG_BRK0] = value[dsac_pkg::MV_W-1:0];
    endtask

    task automatic set_calibration(input int unsigned ref_mv, input int unsigned b0,
                                   input int unsigned b1, input int unsigned b2,
                                   input int unsigned b3, input int unsigned b4,
                                   input int unsigned b5);
        wait_drained();
        write_register(dsac_pkg::CFG_REF, ref_mv);
        write_register(dsac_pkg::CFG_BRK0, b0);
        write_register(dsac_pkg::CFG_IDX_W'(dsac_pkg::CFG_BRK0 + 1), b1);
        write_register(dsac_pkg::CFG_IDX_W'(dsac_pkg::CFG_BRK0 + 2), b2);
        write_register(dsac_pkg::CFG_IDX_W'(dsac_pkg::CFG_BRK0 + 3), b3);
        write_register(dsac_pkg::CFG_IDX_W'(dsac_pkg::CFG_BRK0 + 4), b4);
        write_register(dsac_pkg::CFG_BRK5, b5);
    endtask

    task automatic draw_calibration();
        int unsigned ref_mv, top, mode, pick;
        int unsigned picks [$];
        pick = $urandom_range(0, 9);
        if (pick == 6)      ref_mv = 1000;
        else if (pick == 7) ref_mv = 5000;
        else if (pick == 8) ref_mv = 8191;
        else if (pick == 9) ref_mv = $urandom_range(0, 8191);
        else                ref_mv = $urandom_range(1000, 5000);
        // keep most breakpoints inside the reachable voltage range
        top  = (ref_mv == 0) ? 1 : ref_mv;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < dsac_pkg::NUM_BREAKS; i++) begin
            if (mode <= 5)      picks.push_back($urandom_range(0, top));
            else if (mode == 6) picks.push_back((top / 4) * $urandom_range(0, 4));
            else if (mode == 7) picks.push_back($urandom_range(0, 5000));
            else if (mode == 8) picks.push_back($urandom_range(0, 8191));
            else                picks.push_back($urandom_range(0, 1) ? 8191 : 0);
        end
        if (mode <= 6)
            picks.sort();
        set_calibration(ref_mv, picks[0], picks[1], picks[2], picks[3], picks[4], picks[5]);
    endtask

    task automatic send_bursts(input int unsigned count);
        int unsigned sent, kind, len, level, spread;
        int          v;
        sent = 0;
        while (sent < count) begin
            kind   = $urandom_range(0, 9);
            len    = $urandom_range(4, 30);
            level  = $urandom_range(0, 4095);
            spread = $urandom_range(0, 80);
            for (int k = 0; k < len && sent < count; k++) begin
                if (kind < 7) begin
                    // noisy plateau so the average settles into one segment
                    v = int'(level) + int'($urandom_range(0, 2 * spread)) - int'(spread);
                    if (v < 0)    v = 0;
                    if (v > 4095) v = 4095;
                end else if (kind < 9) begin
                    v = $urandom_range(0, 4095);
                end else begin
                    v = $urandom_range(0, 1) ? 4095 : 0;
                end
                send_sample(v[dsac_pkg::ADC_W-1:0]);
                sent++;
            end
        end
    endtask

    // Register reset values and the partly filled window, with zero and full-scale samples
    task automatic test_reset_calibration();
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'hFFF);
        send_sample(12'hFFF);
        send_sample(12'd0);
    endtask

    // Hold the window at a flat 2000 and move the breakpoints and the reference around it
    task automatic test_calibration_corners();
        wait_drained();
        write_register(dsac_pkg::CFG_REF, 4095);
        repeat (dsac_pkg::WINDOW) send_sample(12'd2000);
        // shared breakpoint between two segments
        set_calibration(4095, 1000, 1500, 2000, 2500, 3000, 3500);
        send_sample(12'd2000);
        // zero-width segment after a reversed one
        set_calibration(4095, 3000, 2000, 2000, 4000, 4500, 5000);
        send_sample(12'd2000);
        // below the first breakpoint
        set_calibration(4095, 2500, 2600, 2700, 2800, 2900, 3000);
        send_sample(12'd2000);
        // above the last breakpoint
        set_calibration(4095, 0, 100, 200, 300, 400, 1999);
        send_sample(12'd2000);
        // reference at both ends of the register width
        set_calibration(8191, 0, 100, 200, 300, 400, 1999);
        send_sample(12'd2000);
        set_calibration(0, 0, 100, 200, 300, 400, 1999);
        send_sample(12'd2000);
        // write past the last register must change nothing
        wait_drained();
        write_register(CFG_UNUSED, 8191);
        send_sample(12'd2000);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        rx_hold = 400;
        repeat (6) send_sample(dsac_pkg::ADC_W'($urandom_range(0, 4095)));
        // pause until the block has handed back everything
        wait_drained();
        repeat (6) send_sample(dsac_pkg::ADC_W'($urandom_range(0, 4095)));
    endtask

    task automatic test_random_calibration();
        for (int p = 0; p < 12; p++) begin
            if (p == 0)
                set_calibration(8191, 0, 1638, 3276, 4914, 6552, 8191);
            else if (p == 1)
                set_calibration(1000, 0, 0, 0, 0, 0, 0);
            else
                draw_calibration();
            steady = (p % 4 == 3);
            send_bursts(160);
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        steady         = 1'b0;
        rx_hold        = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        for (int k = 0; k < dsac_pkg::WINDOW; k++)
            avg_ring[k] = '0;
        avg_sum    = 0;
        avg_slot   = 0;
        avg_fill   = 0;
        cal_ref_mv = dsac_pkg::REF_RESET;
        for (int k = 0; k < dsac_pkg::NUM_BREAKS; k++)
            cal_break[k] = dsac_pkg::BRK_RESET[k];

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_calibration();
        test_calibration_corners();
        test_output_backpressure();
        test_random_calibration();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dsac_pkg.sv
hw/rtl/dsac_div.sv
hw/rtl/dsac_window.sv
hw/rtl/dust_sample_average_and_calibrate.sv
sim/tb.sv
